[rtl/rtf_pkg.sv]
`timescale 1ns / 1ps
package rtf_pkg;

   localparam int COORD_W   = 24;
   localparam int RSSI_W    = 8;
   localparam int POS_W     = 32;
   localparam int RNG_W     = 24;   // widest range entry (FRAC_BITS fraction bits, 8 by default)
   localparam int COEF_W    = 26;   // A, B, D, E
   localparam int SQ_W      = 48;
   localparam int CF_W      = 51;   // C, F
   localparam int DET_W     = 53;
   localparam int NUM_W     = 78;
   localparam int SPLIT_W   = 26;   // low half of C/F for partial products
   localparam int QUO_W     = 33;
   localparam int DIV_LAT   = QUO_W + 3;
   localparam int REG_IDX_W = 3;

   localparam int REF_DBM          = 45;
   localparam int STEPS_PER_DECADE = 25;
   localparam int TABLE_CAP        = 128;
   localparam int SENTINEL_M       = 9999;

   localparam int DEF_FRAC_BITS        = 8;
   localparam int DEF_RSSI_TABLE_DEPTH = 128;

   localparam logic [63:0] ROOT_Q30  = 64'd1177334498;
   localparam logic [63:0] RANGE_DEN = 64'd100 << 30;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ANCHOR1_X,
      REG_ANCHOR1_Y,
      REG_ANCHOR2_X,
      REG_ANCHOR2_Y,
      REG_ANCHOR3_X,
      REG_ANCHOR3_Y,
      REG_FENCE_MIN,
      REG_FENCE_MAX
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic signed [COORD_W-1:0] x3;
      logic signed [COORD_W-1:0] y3;
      logic signed [COORD_W-1:0] fmin;
      logic signed [COORD_W-1:0] fmax;
   } cfg_type;

   localparam logic signed [COORD_W-1:0] RST_ANCHOR2_X = 24'sd13045;
   localparam logic signed [COORD_W-1:0] RST_ANCHOR3_Y = 24'sd14233;
   localparam logic signed [COORD_W-1:0] RST_FENCE_MIN = -24'sd2560;
   localparam logic signed [COORD_W-1:0] RST_FENCE_MAX = 24'sd30720;

   // log-distance range for table index k, elaboration only
   function automatic logic [RNG_W-1:0] range_entry(input int k, input int frac);
      int          n;
      int          q;
      int          m;
      logic [63:0] v;
      logic [63:0] num;
      n = k + 2 * STEPS_PER_DECADE - REF_DBM;
      q = n / STEPS_PER_DECADE;
      m = n % STEPS_PER_DECADE;
      v = 64'd1 << 30;
      for (int i = 0; i < m; i++) begin
         v = (v * ROOT_Q30 + (64'd1 << 29)) >> 30;
      end
      num = (64'd1 << frac) * v;
      for (int i = 0; i < q; i++) begin
         num = num * 64'd10;
      end
      return RNG_W'((num + RANGE_DEN / 2) / RANGE_DEN);
   endfunction

endpackage

[rtl/rtf_csr.sv]
`timescale 1ns / 1ps
module rtf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [rtf_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [rtf_pkg::COORD_W-1:0]      csr_data,
   output rtf_pkg::cfg_type                 cfg
);
   import rtf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ANCHOR1_X: cfg_in.x1   = csr_data;
            REG_ANCHOR1_Y: cfg_in.y1   = csr_data;
            REG_ANCHOR2_X: cfg_in.x2   = csr_data;
            REG_ANCHOR2_Y: cfg_in.y2   = csr_data;
            REG_ANCHOR3_X: cfg_in.x3   = csr_data;
            REG_ANCHOR3_Y: cfg_in.y3   = csr_data;
            REG_FENCE_MIN: cfg_in.fmin = csr_data;
            REG_FENCE_MAX: cfg_in.fmax = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x1   <= '0;
         cfg_ff.y1   <= '0;
         cfg_ff.x2   <= RST_ANCHOR2_X;
         cfg_ff.y2   <= '0;
         cfg_ff.x3   <= '0;
         cfg_ff.y3   <= RST_ANCHOR3_Y;
         cfg_ff.fmin <= RST_FENCE_MIN;
         cfg_ff.fmax <= RST_FENCE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/rtf_range_rom.sv]
`timescale 1ns / 1ps
module rtf_range_rom #(
   parameter int FRAC_BITS        = rtf_pkg::DEF_FRAC_BITS,
   parameter int RSSI_TABLE_DEPTH = rtf_pkg::DEF_RSSI_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic signed [rtf_pkg::RSSI_W-1:0] rssi,
   output logic [rtf_pkg::RNG_W-1:0]       range_out
);
   import rtf_pkg::*;

   localparam int TOP = (RSSI_TABLE_DEPTH - 1 > TABLE_CAP) ? TABLE_CAP : RSSI_TABLE_DEPTH - 1;
   localparam int IW  = $clog2(TOP + 1);

   logic [RNG_W-1:0] tbl [TOP+1];

   for (genvar g = 0; g <= TOP; g++) begin : g_tbl
      localparam logic [RNG_W-1:0] ENT = range_entry(g, FRAC_BITS);
      assign tbl[g] = ENT;
   end

   logic signed [RSSI_W:0] neg_k;
   logic [IW-1:0]          idx;
   logic [RNG_W-1:0]       range_ff;

   always_comb begin
      neg_k = -$signed({rssi[RSSI_W-1], rssi});
      priority if (neg_k < 0) begin
         idx = '0;                       // positive reading
      end else if (neg_k > (RSSI_W+1)'(TOP)) begin
         idx = IW'(TOP);
      end else begin
         idx = neg_k[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         range_ff <= tbl[idx];
      end
   end

   assign range_out = range_ff;

endmodule

[rtl/rtf_divider.sv]
`timescale 1ns / 1ps
module rtf_divider (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [rtf_pkg::NUM_W-1:0]    num,
   input  logic signed [rtf_pkg::DET_W-1:0]    den,
   output logic signed [rtf_pkg::POS_W-1:0]    quo
);
   import rtf_pkg::*;

   localparam int NW = NUM_W + 1;   // 2|num| + |den|
   localparam int DW = DET_W + 1;   // 2|den|, also remainder width

   // magnitude stage
   logic [NUM_W-1:0] a_ff;
   logic [DET_W-1:0] d_ff;
   logic             neg0_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         d_ff    <= den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
         neg0_ff <= num[NUM_W-1] ^ den[DET_W-1];
      end
   end

   // rounding offset and overflow check
   logic [NW-1:0]    n_in;
   logic [DW-1:0]    dd_in;
   logic [DW-1:0]    rem_ff [QUO_W+1];
   logic [QUO_W-1:0] nlo_ff [QUO_W+1];
   logic [DW-1:0]    dd_ff  [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             sat_ff [QUO_W+1];

   always_comb begin
      n_in  = {a_ff, 1'b0} + NW'(d_ff);
      dd_in = {d_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= DW'(n_in[NW-1:QUO_W]);
         nlo_ff[0] <= n_in[QUO_W-1:0];
         dd_ff[0]  <= dd_in;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg0_ff;
         sat_ff[0] <= (DW+1)'(n_in[NW-1:QUO_W]) >= (DW+1)'(dd_in);
      end
   end

   // one quotient bit per stage
   for (genvar j = 0; j < QUO_W; j++) begin : g_iter
      logic [DW:0] trial;
      logic        ge;
      always_comb begin
         trial = {rem_ff[j], nlo_ff[j][QUO_W-1-j]};
         ge    = trial >= {1'b0, dd_ff[j]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j+1] <= ge ? DW'(trial - {1'b0, dd_ff[j]}) : trial[DW-1:0];
            nlo_ff[j+1] <= nlo_ff[j];
            dd_ff[j+1]  <= dd_ff[j];
            q_ff[j+1]   <= {q_ff[j][QUO_W-2:0], ge};
            neg_ff[j+1] <= neg_ff[j];
            sat_ff[j+1] <= sat_ff[j];
         end
      end
   end

   // saturate and apply sign
   logic [QUO_W-1:0]        lim;
   logic [QUO_W-1:0]        mq;
   logic signed [POS_W-1:0] quo_ff;

   always_comb begin
      lim = neg_ff[QUO_W] ? (QUO_W'(1) << (POS_W - 1)) : ((QUO_W'(1) << (POS_W - 1)) - 1'b1);
      mq  = (sat_ff[QUO_W] || q_ff[QUO_W] > lim) ? lim : q_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff <= neg_ff[QUO_W] ? POS_W'(~mq + 1'b1) : POS_W'(mq);
      end
   end

   assign quo = quo_ff;

endmodule

[rtl/rssi_trilateration_fence.sv]
`timescale 1ns / 1ps
// Pipeline: 5 solve stages, 36 divider stages and 1 output stage from input transfer to
//   result; the 33-stage restoring divider, one quotient bit per stage, is the deepest part.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active high; clears valid bits and loads the register defaults.
module rssi_trilateration_fence #(
   parameter int FRAC_BITS        = rtf_pkg::DEF_FRAC_BITS,
   parameter int RSSI_TABLE_DEPTH = rtf_pkg::DEF_RSSI_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [rtf_pkg::RSSI_W-1:0]  req_rssi_first,
   input  logic signed [rtf_pkg::RSSI_W-1:0]  req_rssi_second,
   input  logic signed [rtf_pkg::RSSI_W-1:0]  req_rssi_third,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [rtf_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [rtf_pkg::POS_W-1:0]   rsp_pos_y,
   output logic                               rsp_degenerate,
   output logic                               rsp_outside_fence,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rtf_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [rtf_pkg::COORD_W-1:0]        csr_data
);
   import rtf_pkg::*;

   localparam int PRE = 5;   // solve stages ahead of the divider
   localparam logic signed [POS_W-1:0] SENTINEL = POS_W'(-(SENTINEL_M * (1 << FRAC_BITS)));

   // ---------------- handshake ----------------
   // Global advance: the pipeline moves whenever the output register is free or
   // being drained this cycle.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   cfg_type cfg;

   rtf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // valid bits travel with the data
   logic [PRE-1:0]     pv_ff;
   logic [DIV_LAT-1:0] dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= '0;
         dv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pv_ff        <= {pv_ff[PRE-2:0], req_valid};
         dv_ff        <= {dv_ff[DIV_LAT-2:0], pv_ff[PRE-1]};
         rsp_valid_ff <= dv_ff[DIV_LAT-1];
      end
   end

   // ---------------- stage 1: range lookup, linear coefficients ----------------
   logic [RNG_W-1:0] r1, r2, r3;

   rtf_range_rom #(.FRAC_BITS(FRAC_BITS), .RSSI_TABLE_DEPTH(RSSI_TABLE_DEPTH)) u_rom1 (
      .clock(clock), .enable(adv), .rssi(req_rssi_first), .range_out(r1));
   rtf_range_rom #(.FRAC_BITS(FRAC_BITS), .RSSI_TABLE_DEPTH(RSSI_TABLE_DEPTH)) u_rom2 (
      .clock(clock), .enable(adv), .rssi(req_rssi_second), .range_out(r2));
   rtf_range_rom #(.FRAC_BITS(FRAC_BITS), .RSSI_TABLE_DEPTH(RSSI_TABLE_DEPTH)) u_rom3 (
      .clock(clock), .enable(adv), .rssi(req_rssi_third), .range_out(r3));

   logic signed [COEF_W-1:0] a_in, b_in, d_in, e_in;
   logic signed [COEF_W-1:0] a_ff, b_ff, d_ff, e_ff;

   // A = 2(x2-x1), B = 2(y2-y1), D = 2(x3-x2), E = 2(y3-y2)
   always_comb begin
      a_in = (COEF_W'(cfg.x2) - COEF_W'(cfg.x1)) <<< 1;
      b_in = (COEF_W'(cfg.y2) - COEF_W'(cfg.y1)) <<< 1;
      d_in = (COEF_W'(cfg.x3) - COEF_W'(cfg.x2)) <<< 1;
      e_in = (COEF_W'(cfg.y3) - COEF_W'(cfg.y2)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   // ---------------- stage 2: squares and determinant products ----------------
   logic [SQ_W-1:0]               sr1_ff, sr2_ff, sr3_ff;
   logic signed [SQ_W-1:0]        sx1_ff, sy1_ff, sx2_ff, sy2_ff, sx3_ff, sy3_ff;
   logic signed [2*COEF_W-1:0]    ae_ff, bd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sr1_ff <= SQ_W'(r1) * SQ_W'(r1);
         sr2_ff <= SQ_W'(r2) * SQ_W'(r2);
         sr3_ff <= SQ_W'(r3) * SQ_W'(r3);
         sx1_ff <= cfg.x1 * cfg.x1;
         sy1_ff <= cfg.y1 * cfg.y1;
         sx2_ff <= cfg.x2 * cfg.x2;
         sy2_ff <= cfg.y2 * cfg.y2;
         sx3_ff <= cfg.x3 * cfg.x3;
         sy3_ff <= cfg.y3 * cfg.y3;
         ae_ff  <= a_ff * e_ff;
         bd_ff  <= b_ff * d_ff;
      end
   end

   // ---------------- stage 3: right-hand sides and determinant ----------------
   logic signed [CF_W-1:0]  c_in, f_in;
   logic signed [CF_W-1:0]  c_ff, f_ff;
   logic signed [DET_W-1:0] det_ff;

   always_comb begin
      c_in = $signed(CF_W'(sr1_ff)) - $signed(CF_W'(sr2_ff))
           - CF_W'(sx1_ff) + CF_W'(sx2_ff) - CF_W'(sy1_ff) + CF_W'(sy2_ff);
      f_in = $signed(CF_W'(sr2_ff)) - $signed(CF_W'(sr3_ff))
           - CF_W'(sx2_ff) + CF_W'(sx3_ff) - CF_W'(sy2_ff) + CF_W'(sy3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff   <= c_in;
         f_ff   <= f_in;
         det_ff <= DET_W'(ae_ff) - DET_W'(bd_ff);
      end
   end

   // ---------------- stage 4: split partial products ----------------
   // C and F are cut into an unsigned low half and a signed high half so that
   // no multiplier exceeds 27 x 26 bits.
   localparam int HI_W = CF_W - SPLIT_W;
   localparam int PL_W = SPLIT_W + 1 + COEF_W;
   localparam int PH_W = HI_W + COEF_W;

   logic signed [SPLIT_W:0]  c_lo, f_lo;
   logic signed [HI_W-1:0]   c_hi, f_hi;
   logic signed [PL_W-1:0]   ce_lo_ff, fb_lo_ff, af_lo_ff, cd_lo_ff;
   logic signed [PH_W-1:0]   ce_hi_ff, fb_hi_ff, af_hi_ff, cd_hi_ff;
   logic signed [DET_W-1:0]  det4_ff;
   logic                     dz4_ff;

   always_comb begin
      c_lo = $signed({1'b0, c_ff[SPLIT_W-1:0]});
      f_lo = $signed({1'b0, f_ff[SPLIT_W-1:0]});
      c_hi = c_ff[CF_W-1:SPLIT_W];
      f_hi = f_ff[CF_W-1:SPLIT_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ce_lo_ff <= c_lo * e_ff;
         ce_hi_ff <= c_hi * e_ff;
         fb_lo_ff <= f_lo * b_ff;
         fb_hi_ff <= f_hi * b_ff;
         af_lo_ff <= f_lo * a_ff;
         af_hi_ff <= f_hi * a_ff;
         cd_lo_ff <= c_lo * d_ff;
         cd_hi_ff <= c_hi * d_ff;
         det4_ff  <= det_ff;
         dz4_ff   <= (det_ff == '0);
      end
   end

   // ---------------- stage 5: Cramer numerators ----------------
   logic signed [NUM_W-1:0] ce, fb, af, cd;
   logic signed [NUM_W-1:0] numx_ff, numy_ff;
   logic signed [DET_W-1:0] det5_ff;
   logic                    dz5_ff;

   always_comb begin
      ce = (NUM_W'(ce_hi_ff) <<< SPLIT_W) + NUM_W'(ce_lo_ff);
      fb = (NUM_W'(fb_hi_ff) <<< SPLIT_W) + NUM_W'(fb_lo_ff);
      af = (NUM_W'(af_hi_ff) <<< SPLIT_W) + NUM_W'(af_lo_ff);
      cd = (NUM_W'(cd_hi_ff) <<< SPLIT_W) + NUM_W'(cd_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         numx_ff <= ce - fb;
         numy_ff <= af - cd;
         det5_ff <= det4_ff;
         dz5_ff  <= dz4_ff;
      end
   end

   // ---------------- divider lanes ----------------
   logic signed [POS_W-1:0] qx, qy;

   rtf_divider u_div_x (
      .clock(clock), .enable(adv), .num(numx_ff), .den(det5_ff), .quo(qx));
   rtf_divider u_div_y (
      .clock(clock), .enable(adv), .num(numy_ff), .den(det5_ff), .quo(qy));

   // degenerate flag rides alongside the divider
   logic [DIV_LAT-1:0] dg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dg_ff <= {dg_ff[DIV_LAT-2:0], dz5_ff};
      end
   end

   // ---------------- output register: sentinel and fence ----------------
   logic signed [POS_W-1:0] px_in, py_in, fmin_w, fmax_w;
   logic                    out_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic                    degen_ff, outside_ff;

   always_comb begin
      px_in  = dg_ff[DIV_LAT-1] ? SENTINEL : qx;
      py_in  = dg_ff[DIV_LAT-1] ? SENTINEL : qy;
      fmin_w = POS_W'(cfg.fmin);
      fmax_w = POS_W'(cfg.fmax);
      out_in = (px_in < fmin_w) || (px_in > fmax_w) || (py_in < fmin_w) || (py_in > fmax_w);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff   <= px_in;
         pos_y_ff   <= py_in;
         degen_ff   <= dg_ff[DIV_LAT-1];
         outside_ff <= out_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_degenerate    = degen_ff;
   assign rsp_outside_fence = outside_ff;

`ifndef SYNTH
   // a degenerate result always carries the sentinel on both axes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_pos_x == SENTINEL && rsp_pos_y == SENTINEL)
      else $error("degenerate result without sentinel");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result freezes the valid pipeline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(pv_ff) && $stable(dv_ff))
      else $error("pipeline moved during output stall");
`endif

endmodule

[tb/rssi_trilateration_fence_tb.sv]
`timescale 1ns / 1ps
module rssi_trilateration_fence_tb;
   import rtf_pkg::*;

   localparam int  HALF_PERIOD   = 6;
   localparam int  CYCLE_LIMIT   = 400000;
   localparam int  DRAIN_CYCLES  = 60;     // a margin past the full pipeline depth
   localparam int  RANDOM_ITEMS  = 100;    // per random phase, five phases

   // one solved position, as it leaves the block
   typedef struct {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic             degenerate;
      logic             outside;
   } fix_type;

   // Position predictor plus queue of expected fixes.
   class fix_scoreboard;
      logic signed [COORD_W-1:0] anchor_reg[8];
      fix_type                   fix_q[$];
      int                        errors;

      function new();
         anchor_reg[REG_ANCHOR1_X] = 0;
         anchor_reg[REG_ANCHOR1_Y] = 0;
         anchor_reg[REG_ANCHOR2_X] = 13045;
         anchor_reg[REG_ANCHOR2_Y] = 0;
         anchor_reg[REG_ANCHOR3_X] = 0;
         anchor_reg[REG_ANCHOR3_Y] = 14233;
         anchor_reg[REG_FENCE_MIN] = -2560;
         anchor_reg[REG_FENCE_MAX] = 30720;
         errors = 0;
      endfunction

      task report(input string what, input logic [63:0] got, input logic [63:0] want);
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      // log-distance range, metres * 2^8
      function automatic logic signed [127:0] range_of(input logic signed [7:0] dbm);
         int           k;
         int           q;
         int           m;
         logic [127:0] v;
         logic [127:0] num;
         logic [127:0] den;
         k = -int'(dbm);
         if (k < 0) k = 0;
         if (k > 127) k = 127;
         q = (k + 5) / 25;
         m = (k + 5) % 25;
         v = 128'd1 << 30;
         for (int i = 0; i < m; i++) v = (v * 128'd1177334498 + (128'd1 << 29)) >> 30;
         num = v << 8;
         for (int i = 0; i < q; i++) num = num * 10;
         den = 128'd100 << 30;
         return (num + den / 2) / den;
      endfunction

      // nearest, ties away from zero, clipped to 32 bits
      function automatic logic signed [63:0] round_quot(input logic signed [127:0] num,
                                                        input logic signed [127:0] den);
         logic         neg;
         logic [127:0] an;
         logic [127:0] dn;
         logic [127:0] qt;
         logic [127:0] lim;
         neg = (num < 0) != (den < 0);
         an  = num < 0 ? -num : num;
         dn  = den < 0 ? -den : den;
         qt  = (2 * an + dn) / (2 * dn);
         lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (qt > lim) qt = lim;
         return neg ? -$signed(qt[63:0]) : $signed(qt[63:0]);
      endfunction

      function void note(input logic signed [7:0] s1, input logic signed [7:0] s2,
                         input logic signed [7:0] s3);
         logic signed [127:0] r1, r2, r3, x1, y1, x2, y2, x3, y3;
         logic signed [127:0] ca, cb, cd, ce, cc, cf, det;
         logic signed [63:0]  px, py, fmin, fmax;
         fix_type             f;
         r1 = range_of(s1); r2 = range_of(s2); r3 = range_of(s3);
         x1 = anchor_reg[REG_ANCHOR1_X]; y1 = anchor_reg[REG_ANCHOR1_Y];
         x2 = anchor_reg[REG_ANCHOR2_X]; y2 = anchor_reg[REG_ANCHOR2_Y];
         x3 = anchor_reg[REG_ANCHOR3_X]; y3 = anchor_reg[REG_ANCHOR3_Y];
         fmin = anchor_reg[REG_FENCE_MIN];
         fmax = anchor_reg[REG_FENCE_MAX];
         ca = 2 * (x2 - x1); cb = 2 * (y2 - y1);
         cd = 2 * (x3 - x2); ce = 2 * (y3 - y2);
         cc = r1*r1 - r2*r2 - x1*x1 + x2*x2 - y1*y1 + y2*y2;
         cf = r2*r2 - r3*r3 - x2*x2 + x3*x3 - y2*y2 + y3*y3;
         det = ca * ce - cb * cd;
         if (det == 0) begin
            px = -64'sd9999 * 256;
            py = px;
            f.degenerate = 1'b1;
         end else begin
            px = round_quot(cc * ce - cf * cb, det);
            py = round_quot(ca * cf - cc * cd, det);
            f.degenerate = 1'b0;
         end
         f.pos_x   = px[31:0];
         f.pos_y   = py[31:0];
         f.outside = (px < fmin || px > fmax || py < fmin || py > fmax);
         fix_q.push_back(f);
      endfunction

      task check(input fix_type got);
         fix_type want;
         if (fix_q.size() == 0) begin
            report("unexpected transfer", 64'(got.pos_x), 64'd0);
         end else begin
            want = fix_q.pop_front();
            if (got.pos_x !== want.pos_x)
               report("pos_x", 64'(got.pos_x), 64'(want.pos_x));
            if (got.pos_y !== want.pos_y)
               report("pos_y", 64'(got.pos_y), 64'(want.pos_y));
            if (got.degenerate !== want.degenerate)
               report("degenerate", 64'(got.degenerate), 64'(want.degenerate));
            if (got.outside !== want.outside)
               report("outside_fence", 64'(got.outside), 64'(want.outside));
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [RSSI_W-1:0]  req_rssi_first = '0;
   logic signed [RSSI_W-1:0]  req_rssi_second = '0;
   logic signed [RSSI_W-1:0]  req_rssi_third = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [POS_W-1:0]   rsp_pos_x;
   logic signed [POS_W-1:0]   rsp_pos_y;
   logic                      rsp_degenerate;
   logic                      rsp_outside_fence;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [REG_IDX_W-1:0]      csr_index = '0;
   logic [COORD_W-1:0]        csr_data = '0;

   fix_scoreboard fixes = new();
   int            req_idle_pct = 0;   // sender gap odds, percent
   int            rsp_idle_pct = 0;   // receiver stall odds, percent
   int            cycle_count = 0;

   rssi_trilateration_fence dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // result monitor: sample at the edge, before any update lands
   always @(posedge clock) begin
      fix_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pos_x      = rsp_pos_x;
         got.pos_y      = rsp_pos_y;
         got.degenerate = rsp_degenerate;
         got.outside    = rsp_outside_fence;
         fixes.check(got);
      end
   end

   // one register write; block must be idle
   task write_reg(input reg_index_type idx, input logic signed [COORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      fixes.anchor_reg[idx] = val;
      csr_valid <= 1'b0;
   endtask

   task write_all(input logic signed [COORD_W-1:0] ax, input logic signed [COORD_W-1:0] ay,
                  input logic signed [COORD_W-1:0] bx, input logic signed [COORD_W-1:0] by,
                  input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
                  input logic signed [COORD_W-1:0] lo, input logic signed [COORD_W-1:0] hi);
      write_reg(REG_ANCHOR1_X, ax);
      write_reg(REG_ANCHOR1_Y, ay);
      write_reg(REG_ANCHOR2_X, bx);
      write_reg(REG_ANCHOR2_Y, by);
      write_reg(REG_ANCHOR3_X, cx);
      write_reg(REG_ANCHOR3_Y, cy);
      write_reg(REG_FENCE_MIN, lo);
      write_reg(REG_FENCE_MAX, hi);
      @(posedge clock);
   endtask

   // one reading set; valid stays up into the next transfer unless a gap is drawn
   task send_readings(input logic signed [7:0] s1, input logic signed [7:0] s2,
                      input logic signed [7:0] s3);
      req_valid       <= 1'b1;
      req_rssi_first  <= s1;
      req_rssi_second <= s2;
      req_rssi_third  <= s3;
      do @(posedge clock); while (req_stall);
      fixes.note(s1, s2, s3);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
   endtask

   task end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // every transfer yields a fix, so an empty queue plus pipeline depth means idle
   task drain();
      while (fixes.fix_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly nominal readings, sometimes any byte (positive and -128 clamp)
   function automatic logic signed [7:0] pick_dbm();
      if ($urandom_range(9) == 0) return $signed(8'($urandom_range(255)));
      return -$signed(8'($urandom_range(127)));
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      if ($urandom_range(3) == 0) return $signed(COORD_W'($urandom));
      return $signed(COORD_W'($urandom_range(51200))) - 24'sd25600;
   endfunction

   task random_burst(input int count);
      for (int i = 0; i < count; i++) send_readings(pick_dbm(), pick_dbm(), pick_dbm());
      end_burst();
   endtask

   initial begin
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hi;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default anchors: nearest, farthest, clamps, byte extremes
      send_readings(0, 0, 0);
      send_readings(-127, -127, -127);
      send_readings(-128, -128, -128);
      send_readings(127, 1, 8'sh55);
      send_readings(-45, -45, -45);
      send_readings(-20, -70, -90);
      send_readings(-100, -30, -60);
      send_readings(-1, -127, 0);
      send_readings(8'sh2a, -86, -43);
      send_readings(-50, -50, -120);
      end_burst();
      drain();

      // collinear anchors: zero determinant, sentinel under an inverted fence
      write_all(0, 0, 2560, 0, 5120, 0, 1000, -1000);
      send_readings(-40, -50, -60);
      send_readings(0, -128, 5);
      end_burst();
      drain();
      // same line, fence wide open: sentinel sits inside
      write_all(100, 100, 100, 100, 100, 100, -24'sd8388608, 24'sd8388607);
      send_readings(-10, -90, -127);
      send_readings(-64, -64, -64);
      end_burst();
      drain();

      // coordinate extremes, drives the quotient into saturation
      write_all(-24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608,
                -24'sd8388608, -24'sd8388608, -24'sd8388608, 24'sd8388607);
      send_readings(0, -127, -60);
      send_readings(-128, 0, 127);
      send_readings(-30, -30, -30);
      end_burst();
      drain();
      write_all(0, 0, 1, 0, 0, 1, 0, 0);
      send_readings(0, -127, -127);
      send_readings(-127, 0, -127);
      end_burst();
      drain();

      // random phases: the first with no idling at all, the rest with idling
      for (int phase = 0; phase < 5; phase++) begin
         req_idle_pct = phase == 0 ? 0 : 20;
         rsp_idle_pct = phase == 0 ? 0 : 20;
         lo = pick_coord();
         hi = pick_coord();
         if (phase == 4 && hi < lo) {lo, hi} = {hi, lo};
         write_all(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord(), lo, hi);
         random_burst(RANDOM_ITEMS);
         drain();
      end

      if (fixes.errors == 0 && fixes.fix_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rtf_pkg.sv
rtl/rtf_csr.sv
rtl/rtf_range_rom.sv
rtl/rtf_divider.sv
rtl/rssi_trilateration_fence.sv
tb/rssi_trilateration_fence_tb.sv
